FILE: rtl/http_chunked_body_decoder_unit_assert.svh
// Assertion macros shared by the decoder modules.
// Each macro checks an implication on the rising edge of clock, with reset held off.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define HCBD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HCBD_ASSERT_NOW(lbl, ante, cons, msg)
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

   localparam int CAPACITY_W       = 25;
   localparam int LEN_BITS_DEFAULT = 24;
   localparam int COMMITTED_W      = 24;
   localparam int REQ_TDATA_W      = 8;
   localparam int RSP_TDATA_W      = 40;
   localparam int RSP_PAD_W        = RSP_TDATA_W - 8 - 1 - COMMITTED_W;

   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 25'd4194304;
   localparam logic [CAPACITY_W-1:0] SIZE_SAT       = '1;

   localparam logic [7:0] CR_BYTE      = 8'h0D;
   localparam logic [1:0] TRAILER_SKIP = 2'd2;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // Result queue between the decoder and the result port
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                   kind;
      logic [7:0]             payload_byte;
      logic                   status;
      logic [COMMITTED_W-1:0] committed_length;
      logic                   run_last;
   } rsp_item_type;

   // Up to two results per accepted beat, first one first
   typedef struct packed {
      logic [1:0]   num;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_push_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_digit(input logic [7:0] b);
      hex_digit_type h;
      h = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.valid = 1'b1;
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.valid = 1'b1;
         h.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.valid = 1'b1;
         h.value = 4'(b - 8'h37);
      end
      return h;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/hcbd_core.sv
`default_nettype none

module hcbd_core #(
   parameter int LEN_BITS = hcbd_pkg::LEN_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [hcbd_pkg::CAPACITY_W-1:0]  csr_wr_data,
   input  wire logic                             in_accept,
   input  wire logic [7:0]                       in_byte,
   input  wire logic                             in_last,
   output hcbd_pkg::rsp_push_type                push
);
   import hcbd_pkg::*;

   localparam int SUM_W = ((LEN_BITS > CAPACITY_W) ? LEN_BITS : CAPACITY_W) + 1;

   typedef enum logic [2:0] {
      PH_DIGITS,
      PH_TO_CR,
      PH_AFTER_CR,
      PH_DATA,
      PH_TRAILER,
      PH_DONE
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [CAPACITY_W-1:0] capacity_ff, capacity_in;
   logic [CAPACITY_W-1:0] size_accum_ff, size_accum_in;
   logic [CAPACITY_W-1:0] bytes_left_ff, bytes_left_in;
   logic [LEN_BITS-1:0]   committed_ff, committed_in;
   logic [1:0]            skip_left_ff, skip_left_in;

   hex_digit_type         hex;
   logic                  line_done;
   logic [SUM_W-1:0]      cap_lim, cap_ext, cap_eff, commit_sum;
   logic [CAPACITY_W-1:0] bytes_dec;
   logic [1:0]            skip_dec;
   rsp_item_type          payload_item, status_item;
   logic                  has_payload;

   always_comb begin
      hex      = hex_digit(in_byte);
      cap_lim  = SUM_W'(1) << LEN_BITS;
      cap_ext  = SUM_W'(capacity_ff);
      cap_eff  = (cap_ext > cap_lim) ? cap_lim : cap_ext;
      commit_sum = SUM_W'(committed_ff) + SUM_W'(size_accum_ff);
      bytes_dec = (bytes_left_ff != '0) ? bytes_left_ff - CAPACITY_W'(1) : bytes_left_ff;
      skip_dec  = (skip_left_ff != '0) ? skip_left_ff - 2'd1 : skip_left_ff;

      capacity_in   = csr_wr_en ? csr_wr_data : capacity_ff;
      phase_in      = phase_ff;
      size_accum_in = size_accum_ff;
      bytes_left_in = bytes_left_ff;
      committed_in  = committed_ff;
      skip_left_in  = skip_left_ff;
      line_done     = 1'b0;
      has_payload   = 1'b0;

      if (in_accept) begin
         case (phase_ff)
            PH_DIGITS: begin
               if (hex.valid) begin
                  // saturate once the next shift would overflow
                  if (size_accum_ff[CAPACITY_W-1 -: 4] != 4'd0) begin
                     size_accum_in = SIZE_SAT;
                  end else begin
                     size_accum_in = {size_accum_ff[CAPACITY_W-5:0], hex.value};
                  end
               end else if (in_byte == CR_BYTE) begin
                  line_done = 1'b1;
               end else begin
                  phase_in = PH_TO_CR;
               end
            end
            PH_TO_CR: begin
               if (in_byte == CR_BYTE) begin
                  line_done = 1'b1;
               end
            end
            PH_AFTER_CR: begin
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               has_payload   = 1'b1;
               bytes_left_in = bytes_dec;
               if (bytes_dec == '0) begin
                  committed_in  = LEN_BITS'(commit_sum);
                  size_accum_in = '0;
                  skip_left_in  = TRAILER_SKIP;
                  phase_in      = PH_TRAILER;
               end
            end
            PH_TRAILER: begin
               skip_left_in = skip_dec;
               if (skip_dec == '0) begin
                  size_accum_in = '0;
                  phase_in      = PH_DIGITS;
               end
            end
            default: begin
            end
         endcase

         if (line_done) begin
            if (size_accum_ff == '0 || commit_sum >= cap_eff) begin
               phase_in = PH_DONE;
            end else begin
               bytes_left_in = size_accum_ff;
               phase_in      = PH_AFTER_CR;
            end
         end
      end

      payload_item                  = '0;
      payload_item.kind             = KIND_PAYLOAD;
      payload_item.payload_byte     = in_byte;
      payload_item.run_last         = !in_last;

      status_item                   = '0;
      status_item.kind              = KIND_STATUS;
      status_item.status            = (committed_in == '0) ? STATUS_EMPTY : STATUS_OK;
      status_item.committed_length  = COMMITTED_W'(committed_in);
      status_item.run_last          = 1'b1;

      push = '0;
      if (has_payload && in_last) begin
         push.num    = 2'd2;
         push.first  = payload_item;
         push.second = status_item;
      end else if (has_payload) begin
         push.num   = 2'd1;
         push.first = payload_item;
      end else if (in_accept && in_last) begin
         push.num   = 2'd1;
         push.first = status_item;
      end

      // end of body: start over for the next one
      if (in_accept && in_last) begin
         phase_in      = PH_DIGITS;
         size_accum_in = '0;
         bytes_left_in = '0;
         committed_in  = '0;
         skip_left_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DIGITS;
         capacity_ff   <= CAPACITY_RESET;
         size_accum_ff <= '0;
         bytes_left_ff <= '0;
         committed_ff  <= '0;
         skip_left_ff  <= '0;
      end else begin
         phase_ff      <= phase_in;
         capacity_ff   <= capacity_in;
         size_accum_ff <= size_accum_in;
         bytes_left_ff <= bytes_left_in;
         committed_ff  <= committed_in;
         skip_left_ff  <= skip_left_in;
      end
   end

`include "http_chunked_body_decoder_unit_assert.svh"

   `HCBD_ASSERT_NEXT(a_last_clears, in_accept && in_last, phase_ff == PH_DIGITS && committed_ff == '0 && size_accum_ff == '0, "body state not cleared after last beat")
   `HCBD_ASSERT_NEXT(a_done_holds, in_accept && !in_last && phase_ff == PH_DONE, phase_ff == PH_DONE, "decoding resumed before end of body")
   `HCBD_ASSERT_NOW(a_data_nonzero, phase_ff == PH_DATA, bytes_left_ff != '0, "data phase with no bytes left")
   `HCBD_ASSERT_NOW(a_pair_order, push.num == 2'd2, push.first.kind == KIND_PAYLOAD && push.second.kind == KIND_STATUS, "two results not payload then status")

endmodule

`default_nettype wire

FILE: rtl/hcbd_queue.sv
`default_nettype none

module hcbd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hcbd_pkg::rsp_push_type push,
   output logic                       room,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output hcbd_pkg::rsp_item_type     out_item
);
   import hcbd_pkg::*;

   rsp_item_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;

   always_comb begin
      out_valid = (count_ff != '0);
      out_item  = mem_ff[head_ff];
      pop       = out_valid && out_ready;
      // hold off the input unless a full pair of results fits
      room      = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
      head_in   = head_ff + QUEUE_PTR_W'(pop);
      tail_in   = tail_ff + QUEUE_PTR_W'(push.num);
      count_in  = count_ff + QUEUE_CNT_W'(push.num) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[tail_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem_ff[tail_ff + QUEUE_PTR_W'(1)] <= push.second;
      end
   end

`include "http_chunked_body_decoder_unit_assert.svh"

   `HCBD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "result queue count out of range")
   `HCBD_ASSERT_NOW(a_push_fits, push.num != 2'd0, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH) - QUEUE_CNT_W'(push.num), "result queue overflow")
   `HCBD_ASSERT_NEXT(a_pop_only, pop && push.num == 2'd0, count_ff == $past(count_ff) - QUEUE_CNT_W'(1), "result queue count not decremented on pop")

endmodule

`default_nettype wire

FILE: rtl/http_chunked_body_decoder_unit.sv
`default_nettype none

// Channel   Direction  tdata (low bit up)                            tuser  tlast
// req       in         wire_byte[7:0]                                -      end_of_wire
// rsp       out        payload_byte, status, committed_length, pad   kind   run_last
// csr       in         capacity[24:0] on csr_wr_en                   -      -
//
// Each request beat is decoded in the cycle it is accepted, one beat per cycle.
// Its results (none, one, or payload then status) land in a 4-entry result
// queue; req_tready stays high while two free entries remain, so the 1 beat per
// cycle rate holds whenever rsp_tready keeps up. A beat with two results is two
// rsp beats. Reset is synchronous and active high; capacity resets to 4 MiB.

module http_chunked_body_decoder_unit #(
   parameter int LEN_BITS = hcbd_pkg::LEN_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [hcbd_pkg::CAPACITY_W-1:0]   csr_wr_data,   // capacity
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [hcbd_pkg::REQ_TDATA_W-1:0]  req_tdata,     // wire_byte
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [hcbd_pkg::RSP_TDATA_W-1:0]       rsp_tdata,     // payload_byte, status,
                                                                 // committed_length
   output logic                                   rsp_tuser,     // kind
   output logic                                   rsp_tlast
);
   import hcbd_pkg::*;

   rsp_push_type push;
   rsp_item_type out_item;
   logic         room;
   logic         req_accept;

   assign req_tready = room;
   assign req_accept = req_tvalid && room;

   hcbd_core #(
      .LEN_BITS (LEN_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_accept   (req_accept),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .push        (push)
   );

   hcbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_item.committed_length, out_item.status,
                       out_item.payload_byte};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.run_last;

endmodule

`default_nettype wire

FILE: tb/sv/tb_http_chunked_body_decoder_unit.sv
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder_unit;
   import hcbd_pkg::*;

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_EXT,
      PH_LF,
      PH_DATA,
      PH_TRAIL,
      PH_DONE
   } body_phase_type;

   class chunk_decode_model;
      logic [CAPACITY_W-1:0]  capacity;
      body_phase_type         phase;
      logic [CAPACITY_W-1:0]  size_acc;
      logic [CAPACITY_W-1:0]  bytes_left;
      logic [COMMITTED_W-1:0] committed;
      logic [1:0]             skip_left;
      rsp_item_type           expected_q[$];
      int unsigned            errors;

      function new();
         capacity = CAPACITY_RESET;
         errors   = 0;
         clear_body();
      endfunction

      function void clear_body();
         phase      = PH_SIZE;
         size_acc   = '0;
         bytes_left = '0;
         committed  = '0;
         skip_left  = '0;
      endfunction

      function int nibble_of(logic [7:0] b);
         if (b >= "0" && b <= "9") return int'(b) - 48;
         if (b >= "a" && b <= "f") return int'(b) - 87;
         if (b >= "A" && b <= "F") return int'(b) - 55;
         return -1;
      endfunction

      // Accept or refuse the chunk whose size line just ended.
      function void close_size_line();
         longint unsigned cap;
         longint unsigned total;
         cap = capacity;
         if (cap > (64'd1 << LEN_BITS_DEFAULT)) cap = 64'd1 << LEN_BITS_DEFAULT;
         total = committed;
         total += size_acc;
         if (size_acc == 0 || total >= cap) begin
            phase = PH_DONE;
         end else begin
            bytes_left = size_acc;
            phase      = PH_LF;
         end
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         rsp_item_type    res[2];
         int              n;
         int              d;
         longint unsigned v;
         n = 0;
         case (phase)
            PH_SIZE: begin
               d = nibble_of(b);
               if (d >= 0) begin
                  v = size_acc;
                  v = v * 16 + d;
                  size_acc = (v > SIZE_SAT) ? SIZE_SAT : CAPACITY_W'(v);
               end else if (b == CR_BYTE) begin
                  close_size_line();
               end else begin
                  phase = PH_EXT;
               end
            end
            PH_EXT: begin
               if (b == CR_BYTE) close_size_line();
            end
            PH_LF: phase = PH_DATA;
            PH_DATA: begin
               res[n] = '0;
               res[n].kind = KIND_PAYLOAD;
               res[n].payload_byte = b;
               n++;
               if (bytes_left > 0) bytes_left--;
               if (bytes_left == 0) begin
                  committed = committed + size_acc[COMMITTED_W-1:0];
                  size_acc  = '0;
                  skip_left = TRAILER_SKIP;
                  phase     = PH_TRAIL;
               end
            end
            PH_TRAIL: begin
               if (skip_left > 0) skip_left--;
               if (skip_left == 0) begin
                  size_acc = '0;
                  phase    = PH_SIZE;
               end
            end
            default: ;
         endcase
         if (last) begin
            res[n] = '0;
            res[n].kind = KIND_STATUS;
            res[n].status = (committed == 0) ? STATUS_EMPTY : STATUS_OK;
            res[n].committed_length = committed;
            n++;
            clear_body();
         end
         if (n > 0) res[n-1].run_last = 1'b1;
         for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type exp_item;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result: kind=%0d byte=%02h status=%0d len=%0d last=%0d",
                             got.kind, got.payload_byte, got.status, got.committed_length,
                             got.run_last));
            return;
         end
         exp_item = expected_q.pop_front();
         if (got.kind !== exp_item.kind || got.payload_byte !== exp_item.payload_byte ||
             got.status !== exp_item.status ||
             got.committed_length !== exp_item.committed_length ||
             got.run_last !== exp_item.run_last)
            report($sformatf({"result mismatch: expected kind=%0d byte=%02h status=%0d len=%0d ",
                              "last=%0d, got kind=%0d byte=%02h status=%0d len=%0d last=%0d"},
                             exp_item.kind, exp_item.payload_byte, exp_item.status,
                             exp_item.committed_length, exp_item.run_last,
                             got.kind, got.payload_byte, got.status, got.committed_length,
                             got.run_last));
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CAPACITY_W-1:0]  csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tlast   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   chunk_decode_model body_model;
   bit                req_quiet = 1'b0;
   int unsigned       ready_hold = 0;

   http_chunked_body_decoder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #6 clock = ~clock;

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Result side: alternate ready stretches and stalls, some of them long.
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         ready_hold = gap_length();
      end else begin
         rsp_tready <= 1'b1;
         ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.kind             = rsp_tuser;
         got.payload_byte     = rsp_tdata[7:0];
         got.status           = rsp_tdata[8];
         got.committed_length = rsp_tdata[9 +: COMMITTED_W];
         got.run_last         = rsp_tlast;
         body_model.check_result(got);
      end
   end

   task automatic push_beat(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = req_quiet ? 0 : gap_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      body_model.note_byte(b, last);
   endtask

   task automatic send_body(ref logic [7:0] q[$]);
      for (int i = 0; i < q.size(); i++) push_beat(q[i], i == q.size() - 1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (body_model.expected_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAPACITY_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      body_model.capacity = value;
   endtask

   function automatic void put_text(ref logic [7:0] q[$], input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   // Hex size digits, random case, one or two leading zeros now and then.
   function automatic void put_size(ref logic [7:0] q[$], input int unsigned sz);
      int          nd;
      int unsigned nib;
      bit          upper;
      nd = 1;
      while ((sz >> (4 * nd)) != 0 && nd < 8) nd++;
      upper = $urandom_range(0, 1);
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) q.push_back("0");
      for (int k = nd - 1; k >= 0; k--) begin
         nib = (sz >> (4 * k)) & 4'hF;
         if (nib < 10) q.push_back(8'(8'h30 + nib));
         else q.push_back(8'((upper ? 8'h41 : 8'h61) + nib - 10));
      end
   endfunction

   function automatic void make_body(ref logic [7:0] q[$]);
      int unsigned sz;
      int unsigned cut;
      int unsigned r;
      q.delete();
      if ($urandom_range(0, 9) == 0) begin
         // noise: random bytes, biased toward framing characters
         repeat ($urandom_range(1, 12)) begin
            r = $urandom_range(0, 3);
            case (r)
               0: q.push_back(CR_BYTE);
               1: q.push_back(8'h0A);
               2: q.push_back("7");
               default: q.push_back(8'($urandom));
            endcase
         end
         return;
      end
      repeat ($urandom_range(0, 4)) begin
         r = $urandom_range(0, 99);
         if (r < 85) sz = $urandom_range(1, 16);
         else if (r < 97) sz = $urandom_range(17, 120);
         else sz = $urandom_range(32'h01FF_FFF0, 32'hFFFF_FFFF);
         if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 3))
               0: q.push_back("+");
               1: q.push_back("-");
               2: q.push_back(" ");
               default: put_text(q, "0x");
            endcase
         end
         put_size(q, sz);
         if ($urandom_range(0, 6) == 0) begin
            q.push_back(";");
            repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(8'h0E, 8'hFF)));
         end
         q.push_back(CR_BYTE);
         q.push_back($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'h0A);
         if (sz > 200) break;
         repeat (sz) q.push_back(8'($urandom));
         if ($urandom_range(0, 9) == 0) begin
            q.push_back(8'($urandom));
            q.push_back(8'($urandom));
         end else begin
            q.push_back(CR_BYTE);
            q.push_back(8'h0A);
         end
      end
      if ($urandom_range(0, 3) != 0) begin
         q.push_back("0");
         q.push_back(CR_BYTE);
         q.push_back(8'h0A);
         q.push_back(CR_BYTE);
         q.push_back(8'h0A);
      end
      if (q.size() == 0) q.push_back(8'($urandom));
      // cut the body short somewhere
      if ($urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, q.size());
         q = q[0:cut-1];
      end
   endfunction

   initial begin
      logic [7:0]            body[$];
      logic [CAPACITY_W-1:0] cap_plan[6];
      int unsigned           phase_items;

      body_model = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // size line with no digit: size zero
      body.delete();
      body.push_back(CR_BYTE);
      send_body(body);
      // hex prefix: the x ends a zero size
      body.delete();
      put_text(body, "0x5");
      body.push_back(CR_BYTE);
      send_body(body);
      // sign ends the size, later bytes are dropped
      body.delete();
      put_text(body, "-3");
      body.push_back(CR_BYTE);
      put_text(body, "\na");
      send_body(body);
      // one full chunk, then one cut off by the end of the body
      body.delete();
      put_text(body, "2");
      body.push_back(CR_BYTE);
      put_text(body, "\nhi");
      body.push_back(CR_BYTE);
      put_text(body, "\n3");
      body.push_back(CR_BYTE);
      put_text(body, "\nA");
      send_body(body);
      // saturated size, refused
      body.delete();
      put_text(body, "FFFFFFF");
      body.push_back(CR_BYTE);
      send_body(body);
      drain();

      cap_plan[0] = 25'd1;
      cap_plan[1] = 25'd16777216;
      cap_plan[2] = 25'($urandom_range(8, 80));
      cap_plan[3] = CAPACITY_RESET;
      cap_plan[4] = 25'($urandom_range(1, 16777216));
      cap_plan[5] = 25'($urandom_range(20, 300));

      foreach (cap_plan[p]) begin
         set_capacity(cap_plan[p]);
         phase_items = 0;
         while (phase_items < 320) begin
            make_body(body);
            req_quiet = ($urandom_range(0, 4) == 0);
            send_body(body);
            phase_items += body.size();
         end
         req_quiet = 1'b0;
         drain();
      end

      if (body_model.errors == 0 && body_model.expected_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #7200000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
